// ===== design/i2c_master_single_byte_writer_macros.svh =====
// Assertion macros for the I2C single byte writer.
`ifndef I2C_MASTER_SINGLE_BYTE_WRITER_MACROS_SVH
`define I2C_MASTER_SINGLE_BYTE_WRITER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define I2CMW_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition never holds.
`define I2CMW_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

// ===== design/i2cmw_pkg.sv =====
// Shared types and constants for the I2C single byte writer.
package i2cmw_pkg;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_START = 2'd1,
    CMD_CONT  = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_t;

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_EVENT  = 1'b1;

  localparam logic [3:0] EV_BUS_ERR   = 4'd0;
  localparam logic [3:0] EV_START     = 4'd1;
  localparam logic [3:0] EV_REP_START = 4'd2;
  localparam logic [3:0] EV_SLAW_ACK  = 4'd3;
  localparam logic [3:0] EV_DATA_ACK  = 4'd4;
  localparam logic [3:0] EV_SLAW_NACK = 4'd5;
  localparam logic [3:0] EV_DATA_NACK = 4'd6;
  localparam logic [3:0] EV_ARB_LOST  = 4'd7;
  localparam logic [3:0] EV_SLAR_ACK  = 4'd8;
  localparam logic [3:0] EV_SLAR_NACK = 4'd9;
  localparam logic [3:0] EV_RX_DATA   = 4'd10;

  localparam logic [7:0] ADDR_RESET = 8'h40;
  localparam logic [7:0] CUR_RESET  = 8'hff;

  typedef struct packed {
    logic       req_type;
    logic [7:0] new_value;
    logic [3:0] bus_event;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    cmd_t       bus_command;
    logic       load_byte;
    logic [7:0] tx_byte;
    logic       error_flag;
    logic       busy_res;
    logic [7:0] confirmed_value;
  } res_t;

endpackage

// ===== design/i2cmw_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface i2cmw_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] new_value;
  logic [3:0] bus_event;
  logic [7:0] rx_byte;

  modport source (output valid, req_type, new_value, bus_event, rx_byte, input ready);
  modport sink (input valid, req_type, new_value, bus_event, rx_byte, output ready);
endinterface

interface i2cmw_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] bus_command;
  logic       load_byte;
  logic [7:0] tx_byte;
  logic       error_flag;
  logic       busy_res;
  logic [7:0] confirmed_value;

  modport source (output valid, bus_command, load_byte, tx_byte, error_flag, busy_res,
                  confirmed_value, input ready);
  modport sink (input valid, bus_command, load_byte, tx_byte, error_flag, busy_res,
                confirmed_value, output ready);
endinterface

// ===== design/i2cmw_in_reg.sv =====
// Input register stage: captures one request beat.
module i2cmw_in_reg (
  input  logic               clk,
  input  logic               rst,
  i2cmw_req_if.sink          req_ch,
  input  logic               take,
  output logic               valid,
  output i2cmw_pkg::req_t    data
);

  assign req_ch.ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (req_ch.ready) begin
      valid <= req_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ch.valid && req_ch.ready) begin
      data.req_type  <= req_ch.req_type;
      data.new_value <= req_ch.new_value;
      data.bus_event <= req_ch.bus_event;
      data.rx_byte   <= req_ch.rx_byte;
    end
  end

endmodule

// ===== design/i2cmw_ctrl.sv =====
// Transfer state and per-item command decision.
module i2cmw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  i2cmw_pkg::req_t    req,
  input  logic [7:0]         slave_address,
  output i2cmw_pkg::res_t    res
);

  logic [7:0] wanted_value, wanted_value_next;
  logic [7:0] in_flight_value, in_flight_value_next;
  logic [7:0] current_value, current_value_next;
  logic       active, active_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_value    <= 8'd0;
      in_flight_value <= 8'd0;
      current_value   <= i2cmw_pkg::CUR_RESET;
      active          <= 1'b1;
    end else if (step) begin
      wanted_value    <= wanted_value_next;
      in_flight_value <= in_flight_value_next;
      current_value   <= current_value_next;
      active          <= active_next;
    end
  end

  always_comb begin
    i2cmw_pkg::cmd_t cmd;
    logic            load;
    logic [7:0]      tx;
    logic            err;

    cmd                  = i2cmw_pkg::CMD_NONE;
    load                 = 1'b0;
    tx                   = 8'd0;
    err                  = 1'b0;
    wanted_value_next    = wanted_value;
    in_flight_value_next = in_flight_value;
    current_value_next   = current_value;
    active_next          = active;

    if (req.req_type == i2cmw_pkg::REQ_UPDATE) begin
      if (wanted_value != req.new_value) begin
        wanted_value_next = req.new_value;
        if (!active) begin
          cmd         = i2cmw_pkg::CMD_START;
          active_next = 1'b1;
        end
      end
    end else if (active) begin
      case (req.bus_event)
        i2cmw_pkg::EV_BUS_ERR: begin
          cmd = i2cmw_pkg::CMD_STOP;
          err = 1'b1;
        end
        i2cmw_pkg::EV_START, i2cmw_pkg::EV_REP_START: begin
          tx   = slave_address;
          load = 1'b1;
          cmd  = i2cmw_pkg::CMD_CONT;
        end
        i2cmw_pkg::EV_SLAW_ACK: begin
          // latch the byte going out so the data ack can confirm it
          in_flight_value_next = wanted_value;
          tx                   = wanted_value;
          load                 = 1'b1;
          cmd                  = i2cmw_pkg::CMD_CONT;
        end
        i2cmw_pkg::EV_DATA_ACK: begin
          current_value_next = in_flight_value;
          active_next        = 1'b0;
        end
        i2cmw_pkg::EV_SLAW_NACK, i2cmw_pkg::EV_DATA_NACK, i2cmw_pkg::EV_SLAR_NACK: begin
          active_next = 1'b0;
          err         = 1'b1;
        end
        i2cmw_pkg::EV_ARB_LOST: begin
          cmd = i2cmw_pkg::CMD_START;
        end
        i2cmw_pkg::EV_SLAR_ACK: begin
          cmd = i2cmw_pkg::CMD_CONT;
        end
        i2cmw_pkg::EV_RX_DATA: begin
          current_value_next = req.rx_byte;
          active_next        = 1'b0;
        end
        default: begin
        end
      endcase
      // transfer ended: restart if a change is still pending and no error was seen, else release the bus
      if (!active_next) begin
        if (wanted_value_next != current_value_next && !err) begin
          cmd         = i2cmw_pkg::CMD_START;
          active_next = 1'b1;
        end else begin
          cmd = i2cmw_pkg::CMD_STOP;
        end
      end
    end

    res.bus_command     = cmd;
    res.load_byte       = load;
    res.tx_byte         = tx;
    res.error_flag      = err;
    res.busy_res        = active_next;
    res.confirmed_value = current_value_next;
  end

endmodule

// ===== design/i2cmw_out_reg.sv =====
// Result register stage: holds one result beat until taken.
module i2cmw_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid_in,
  input  i2cmw_pkg::res_t    data_in,
  output logic               ready_in,
  i2cmw_rsp_if.source        rsp_ch
);

  logic            valid;
  i2cmw_pkg::res_t data;

  assign ready_in = !valid || rsp_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_in) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_in && ready_in) begin
      data <= data_in;
    end
  end

  assign rsp_ch.valid           = valid;
  assign rsp_ch.bus_command     = data.bus_command;
  assign rsp_ch.load_byte       = data.load_byte;
  assign rsp_ch.tx_byte         = data.tx_byte;
  assign rsp_ch.error_flag      = data.error_flag;
  assign rsp_ch.busy_res        = data.busy_res;
  assign rsp_ch.confirmed_value = data.confirmed_value;

endmodule

// ===== design/i2c_master_single_byte_writer.sv =====
// Sequencing controller for an I2C master that keeps one remote port byte current.
// Each request beat (a new wanted value or an encoded bus status) yields exactly one
// result beat carrying the next bus command, an optional byte to load, an error flag,
// the busy state and the confirmed port value. One beat is accepted per cycle when the
// result side keeps up; each beat passes the input register, then the result register;
// one transfer state update per accepted beat sets that rate. After reset the
// controller is busy, as if START had been issued, the confirmed value is 0xff and the
// slave address register holds 0x40; write the address only while no beat is in flight.
`include "i2c_master_single_byte_writer_macros.svh"

module i2c_master_single_byte_writer (
  input  logic         clk,
  input  logic         rst,
  i2cmw_req_if.sink    req_ch,
  i2cmw_rsp_if.source  rsp_ch,
  input  logic         wr_en,
  input  logic [7:0]   wr_data
);

  logic [7:0]      slave_address;
  logic            req_valid;
  i2cmw_pkg::req_t req_data;
  i2cmw_pkg::res_t res_data;
  logic            res_ready;
  logic            step;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= i2cmw_pkg::ADDR_RESET;
    end else if (wr_en) begin
      slave_address <= wr_data;
    end
  end

  // advance the held request into the result register
  assign step = req_valid && res_ready;

  i2cmw_in_reg u_in_reg (
    .clk    (clk),
    .rst    (rst),
    .req_ch (req_ch),
    .take   (res_ready),
    .valid  (req_valid),
    .data   (req_data)
  );

  i2cmw_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .req           (req_data),
    .slave_address (slave_address),
    .res           (res_data)
  );

  i2cmw_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .valid_in (req_valid),
    .data_in  (res_data),
    .ready_in (res_ready),
    .rsp_ch   (rsp_ch)
  );

  `I2CMW_ASSERT_IMPL(a_err_stops, rsp_ch.valid && rsp_ch.error_flag, rsp_ch.bus_command == i2cmw_pkg::CMD_STOP, "error result without STOP")
  `I2CMW_ASSERT_IMPL(a_start_busy, rsp_ch.valid && rsp_ch.bus_command == i2cmw_pkg::CMD_START, rsp_ch.busy_res, "START issued while idle")
  `I2CMW_ASSERT_IMPL(a_tx_zero, rsp_ch.valid && !rsp_ch.load_byte, rsp_ch.tx_byte == 8'd0, "tx byte set without load")
  `I2CMW_ASSERT_NEVER(a_err_no_load, rsp_ch.valid && rsp_ch.error_flag && rsp_ch.load_byte, "byte load on error result")

endmodule
